/* rtl/bbce_pkg.sv */
// Shared types and constants for the byte-budget cache evictor.
// Used by the interfaces, controller, datapath and top level; depends on nothing.
`default_nettype none
package bbce_pkg;

  localparam int BYTES_W     = 40;
  localparam int OBJ_BYTES_W = 32;
  localparam int OBJ_ID_W    = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 7;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 3'd0,
    CMD_GET       = 3'd1,
    CMD_UNLOAD    = 3'd2,
    CMD_RELEASE   = 3'd3,
    CMD_PURGE_ALL = 3'd4,
    CMD_PURGE_ONE = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_HELD      = 3'd3,
    ST_INVALID   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic scan_en;
    logic exec_en;
    logic walk_en;
    logic done_en;
  } ctl_t;

  typedef struct packed {
    logic quick_done;
    logic scan_done;
    logic need_walk;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/bbce_ifs.sv */
// Channel interfaces for command items and result items.
// Depends on bbce_pkg for field widths.
`default_nettype none
interface bbce_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [bbce_pkg::CMD_W-1:0]       cmd;
  logic [bbce_pkg::OBJ_ID_W-1:0]    object_id;
  logic [bbce_pkg::OBJ_BYTES_W-1:0] object_bytes;
  modport source (output valid, cmd, object_id, object_bytes, input ready);
  modport sink (input valid, cmd, object_id, object_bytes, output ready);
endinterface

interface bbce_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bbce_pkg::STATUS_W-1:0] status;
  logic                          hit;
  logic [bbce_pkg::COUNT_W-1:0]  evicted_count;
  logic [bbce_pkg::BYTES_W-1:0]  used_bytes;
  logic [bbce_pkg::COUNT_W-1:0]  entry_count;
  modport source (output valid, status, hit, evicted_count, used_bytes, entry_count,
                  input ready);
  modport sink (input valid, status, hit, evicted_count, used_bytes, entry_count,
                output ready);
endinterface
`default_nettype wire

/* rtl/bbce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module bbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/bbce_ctrl.sv */
// Sequencing state machine of the cache evictor.
// Depends on bbce_pkg for the state, control and datapath-status types.
`default_nettype none
module bbce_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire bbce_pkg::dp_stat_t stat,
  output bbce_pkg::ctl_t          ctl
);
  bbce_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbce_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bbce_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.quick_done ? bbce_pkg::S_DONE : bbce_pkg::S_SCAN;
        end
      end
      bbce_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          state_next = bbce_pkg::S_EXEC;
        end
      end
      bbce_pkg::S_EXEC: begin
        state_next = stat.need_walk ? bbce_pkg::S_WALK : bbce_pkg::S_DONE;
      end
      bbce_pkg::S_WALK: begin
        if (stat.walk_done) begin
          state_next = bbce_pkg::S_DONE;
        end
      end
      bbce_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_next = bbce_pkg::S_IDLE;
        end
      end
      default: state_next = bbce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      bbce_pkg::S_IDLE: ctl.in_ready = 1'b1;
      bbce_pkg::S_SCAN: ctl.scan_en  = 1'b1;
      bbce_pkg::S_EXEC: ctl.exec_en  = 1'b1;
      bbce_pkg::S_WALK: ctl.walk_en  = 1'b1;
      bbce_pkg::S_DONE: ctl.done_en  = 1'b1;
      default: ctl = '0;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/bbce_dp.sv */
// Datapath of the cache evictor: entry table in load order, counters, result register.
// Depends on bbce_pkg and bbce_ram.
`default_nettype none
module bbce_dp #(
  parameter int ENTRIES     = 64,
  parameter int ID_BITS     = 32,
  parameter int HOLDER_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bbce_pkg::ctl_t                      ctl,
  output bbce_pkg::dp_stat_t                       stat,
  input  wire logic [bbce_pkg::BYTES_W-1:0]        max_bytes,
  input  wire logic [bbce_pkg::OBJ_ID_W-1:0]       invalid_id,
  input  wire logic                                in_valid,
  input  wire logic [bbce_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic [bbce_pkg::OBJ_ID_W-1:0]       in_object_id,
  input  wire logic [bbce_pkg::OBJ_BYTES_W-1:0]    in_object_bytes,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [bbce_pkg::STATUS_W-1:0]       out_status,
  output logic                                     out_hit,
  output logic      [bbce_pkg::COUNT_W-1:0]        out_evicted_count,
  output logic      [bbce_pkg::BYTES_W-1:0]        out_used_bytes,
  output logic      [bbce_pkg::COUNT_W-1:0]        out_entry_count
);
  localparam int IW    = $clog2(ENTRIES);
  localparam int LW    = $clog2(ENTRIES + 1);
  localparam int BW    = bbce_pkg::BYTES_W;
  localparam int OBW   = bbce_pkg::OBJ_BYTES_W;
  localparam int ENT_W = ID_BITS + OBW + HOLDER_BITS;

  logic [bbce_pkg::CMD_W-1:0]    cmd_q;
  logic [ID_BITS-1:0]            key_q;
  logic [OBW-1:0]                bytes_q;
  logic [bbce_pkg::STATUS_W-1:0] status_q;
  logic                          hit_q;
  logic [LW-1:0]                 len;
  logic [BW-1:0]                 res;
  logic [LW-1:0]                 r;
  logic [LW-1:0]                 w;
  logic [LW-1:0]                 dropped;
  logic [IW-1:0]                 rd_idx;
  logic                          rd_vld;
  logic                          found;
  logic [IW-1:0]                 f_idx;
  logic [OBW-1:0]                ent_bytes;
  logic [HOLDER_BITS-1:0]        ent_hold;
  logic                          walking;
  logic                          mode_evict;
  logic [IW-1:0]                 last;

  logic                   accept;
  logic                   id_cmd;
  logic                   invalid_hit;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic [ENT_W-1:0]       rdata;
  logic [ID_BITS-1:0]     rd_id;
  logic [OBW-1:0]         rd_bytes;
  logic [HOLDER_BITS-1:0] rd_hold;
  logic                   match;
  logic                   scan_issue;
  logic                   walk_issue;
  logic [BW:0]            sum;
  logic [BW-1:0]          sum_sat;
  logic [BW:0]            ent_diff;
  logic [BW-1:0]          ent_sub;
  logic [BW:0]            rd_diff;
  logic [BW-1:0]          rd_sub;
  logic                   drop;
  logic                   need_walk;
  logic                   load_out;

  assign accept      = ctl.in_ready && in_valid;
  assign id_cmd      = (in_cmd <= bbce_pkg::CMD_RELEASE) || (in_cmd == bbce_pkg::CMD_PURGE_ONE);
  assign invalid_hit = id_cmd && (in_object_id == invalid_id);

  assign rd_id    = rdata[ENT_W-1 -: ID_BITS];
  assign rd_bytes = rdata[HOLDER_BITS +: OBW];
  assign rd_hold  = rdata[HOLDER_BITS-1:0];

  assign match      = ctl.scan_en && rd_vld && (rd_id == key_q);
  assign scan_issue = ctl.scan_en && (r < len) && !match;
  assign walk_issue = ctl.walk_en && (r < len);

  assign sum      = {1'b0, res} + (BW + 1)'(bytes_q);
  assign sum_sat  = sum[BW] ? {BW{1'b1}} : sum[BW-1:0];
  assign ent_diff = {1'b0, res} - (BW + 1)'(ent_bytes);
  assign ent_sub  = ent_diff[BW] ? '0 : ent_diff[BW-1:0];
  assign rd_diff  = {1'b0, res} - (BW + 1)'(rd_bytes);
  assign rd_sub   = rd_diff[BW] ? '0 : rd_diff[BW-1:0];

  assign drop = mode_evict ? (walking && (rd_idx != last) && (rd_hold == '0))
                           : (rd_idx == f_idx);

  assign load_out = ctl.done_en && stat.out_free;

  always_comb begin
    need_walk = 1'b0;
    if (ctl.exec_en && found) begin
      need_walk = (cmd_q == bbce_pkg::CMD_PURGE_ONE) ||
                  ((cmd_q == bbce_pkg::CMD_UNLOAD) && (ent_hold == '0));
    end else if (ctl.exec_en && (cmd_q == bbce_pkg::CMD_LOAD) && (len != LW'(ENTRIES))) begin
      need_walk = (sum_sat >= max_bytes);
    end
  end

  assign stat.quick_done = !id_cmd || invalid_hit;
  assign stat.scan_done  = ctl.scan_en && (match || ((r >= len) && !rd_vld));
  assign stat.need_walk  = need_walk;
  assign stat.walk_done  = ctl.walk_en && (r >= len) && !rd_vld;
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w[IW-1:0];
    ram_wdata = rdata;
    if (ctl.exec_en) begin
      unique case (cmd_q)
        bbce_pkg::CMD_LOAD: begin
          ram_we    = !found && (len != LW'(ENTRIES));
          ram_waddr = len[IW-1:0];
          ram_wdata = {key_q, bytes_q, {HOLDER_BITS{1'b0}}};
        end
        bbce_pkg::CMD_GET: begin
          ram_we    = found;
          ram_waddr = f_idx;
          ram_wdata = {key_q, ent_bytes,
                       (ent_hold == '1) ? ent_hold : ent_hold + 1'b1};
        end
        bbce_pkg::CMD_RELEASE: begin
          ram_we    = found && (ent_hold != '0);
          ram_waddr = f_idx;
          ram_wdata = {key_q, ent_bytes, ent_hold - 1'b1};
        end
        default: ram_we = 1'b0;
      endcase
    end else if (ctl.walk_en && rd_vld && !drop) begin
      ram_we = 1'b1;
    end
  end

  bbce_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (r[IW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      res       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= scan_issue || walk_issue;
      if (accept && (in_cmd == bbce_pkg::CMD_PURGE_ALL)) begin
        len <= '0;
        res <= '0;
      end
      if (ctl.exec_en) begin
        if ((cmd_q == bbce_pkg::CMD_LOAD) && !found && (len != LW'(ENTRIES))) begin
          len <= len + 1'b1;
          res <= sum_sat;
        end else if (need_walk) begin
          res <= ent_sub;
        end
      end
      if (ctl.walk_en && rd_vld && drop && mode_evict) begin
        res <= rd_sub;
      end
      if (stat.walk_done) begin
        len <= w;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= r[IW-1:0];
    if (accept) begin
      cmd_q    <= in_cmd;
      key_q    <= ID_BITS'(in_object_id);
      bytes_q  <= in_object_bytes;
      status_q <= invalid_hit ? bbce_pkg::ST_INVALID : bbce_pkg::ST_OK;
      hit_q    <= 1'b0;
      found    <= 1'b0;
      dropped  <= '0;
      r        <= '0;
    end
    if (scan_issue || walk_issue) begin
      r <= r + 1'b1;
    end
    if (match) begin
      found     <= 1'b1;
      hit_q     <= 1'b1;
      f_idx     <= rd_idx;
      ent_bytes <= rd_bytes;
      ent_hold  <= rd_hold;
    end
    if (ctl.exec_en) begin
      unique case (cmd_q)
        bbce_pkg::CMD_LOAD: begin
          if (found) begin
            status_q <= bbce_pkg::ST_PRESENT;
          end else if (len == LW'(ENTRIES)) begin
            status_q <= bbce_pkg::ST_FULL;
          end else begin
            mode_evict <= 1'b1;
            walking    <= 1'b1;
            r          <= '0;
            w          <= '0;
            last       <= len[IW-1:0];
          end
        end
        bbce_pkg::CMD_UNLOAD: begin
          if (!found) begin
            status_q <= bbce_pkg::ST_NOT_FOUND;
          end else if (ent_hold != '0) begin
            status_q <= bbce_pkg::ST_HELD;
          end
        end
        bbce_pkg::CMD_GET, bbce_pkg::CMD_RELEASE, bbce_pkg::CMD_PURGE_ONE: begin
          if (!found) begin
            status_q <= bbce_pkg::ST_NOT_FOUND;
          end
        end
        default: status_q <= status_q;
      endcase
      if (found && (cmd_q != bbce_pkg::CMD_LOAD)) begin
        mode_evict <= 1'b0;
        r          <= LW'(f_idx);
        w          <= LW'(f_idx);
      end
    end
    if (ctl.walk_en && rd_vld) begin
      if (drop) begin
        if (mode_evict) begin
          dropped <= dropped + 1'b1;
          if (rd_sub < max_bytes) begin
            walking <= 1'b0;
          end
        end
      end else begin
        w <= w + 1'b1;
      end
    end
    if (load_out) begin
      out_status        <= status_q;
      out_hit           <= hit_q;
      out_evicted_count <= bbce_pkg::COUNT_W'(dropped);
      out_used_bytes    <= res;
      out_entry_count   <= bbce_pkg::COUNT_W'(len);
    end
  end
endmodule
`default_nettype wire

/* rtl/byte_budget_cache_evictor_top.sv */
// Top level of the byte-budget cache evictor: channels, APB registers, controller, datapath.
// Depends on bbce_pkg, bbce_ifs, bbce_ctrl and bbce_dp.
//
//   port     | direction | carries
//   cmd_ch   | in        | cmd, object_id, object_bytes
//   rsp_ch   | out       | status, hit, evicted_count, used_bytes, entry_count
//   APB      | in/out    | max_bytes at 0x0, invalid_id at 0x8
//
// One command at a time. A lookup reads the load-ordered table one entry per cycle and stops
// at a hit; an execute state follows, then any walk: removal compacts from the removed entry
// and eviction from the oldest one. The done state then hands over the result, and the idle
// state takes the next command.
// Refused, unknown and purge-all commands skip the scan and go straight to the done state.
// Reset is synchronous and empties the table; a waiting result holds the next command.
`default_nettype none
module byte_budget_cache_evictor_top #(
  parameter int ENTRIES     = 64,
  parameter int ID_BITS     = 32,
  parameter int HOLDER_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  bbce_cmd_if.sink                                  cmd_ch,
  bbce_rsp_if.source                                rsp_ch,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [bbce_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [bbce_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [bbce_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready
);
  logic [bbce_pkg::BYTES_W-1:0]  max_bytes;
  logic [bbce_pkg::OBJ_ID_W-1:0] invalid_id;
  bbce_pkg::ctl_t                ctl;
  bbce_pkg::dp_stat_t            stat;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? bbce_pkg::APB_DATA_W'(invalid_id)
                           : bbce_pkg::APB_DATA_W'(max_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes  <= bbce_pkg::BYTES_W'(40'd1073741824);
      invalid_id <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        invalid_id <= pwdata[bbce_pkg::OBJ_ID_W-1:0];
      end else begin
        max_bytes <= pwdata[bbce_pkg::BYTES_W-1:0];
      end
    end
  end

  assign cmd_ch.ready = ctl.in_ready;

  bbce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_ch.valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  bbce_dp #(
    .ENTRIES     (ENTRIES),
    .ID_BITS     (ID_BITS),
    .HOLDER_BITS (HOLDER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .max_bytes         (max_bytes),
    .invalid_id        (invalid_id),
    .in_valid          (cmd_ch.valid),
    .in_cmd            (cmd_ch.cmd),
    .in_object_id      (cmd_ch.object_id),
    .in_object_bytes   (cmd_ch.object_bytes),
    .out_valid         (rsp_ch.valid),
    .out_ready         (rsp_ch.ready),
    .out_status        (rsp_ch.status),
    .out_hit           (rsp_ch.hit),
    .out_evicted_count (rsp_ch.evicted_count),
    .out_used_bytes    (rsp_ch.used_bytes),
    .out_entry_count   (rsp_ch.entry_count)
  );
endmodule
`default_nettype wire
